// ----- rtl/csg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package csg_pkg;

    // Default sizes of the stores.
    localparam int MAX_ITEMS_DEF  = 1024;
    localparam int MAX_GROUPS_DEF = 256;

    // Field widths of the transactions.
    localparam int OPCODE_W  = 3;
    localparam int KEY_W     = 8;
    localparam int INDEX_W   = 11;
    localparam int VALUE_W   = 11;
    localparam int STATUS_W  = 2;
    localparam int GCFG_W    = 9;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    localparam logic [GCFG_W-1:0] GCFG_RESET = 9'd256;

    // Command codes.
    localparam logic [OPCODE_W-1:0] OP_CLEAR     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH      = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_FINISH    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_RD_OFFSET = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_RD_ORDER  = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_KEY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PHASE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_PFX_RD,
        S_PFX_WR,
        S_SC_KEY,
        S_SC_CUR,
        S_SC_WR,
        S_RD_OFF,
        S_RD_ORD,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/counting_sort_grouper_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Stable counting sort that groups item indices by a small key. Software sends
// a clear, pushes keys one per transaction, sends finish, then reads offsets
// (one more than the group count) and order entries; every command returns
// exactly one result transaction carrying a value and a status. The block
// handles one command at a time and is not ready while a command is at work.
// A clear, a rejected command or an unknown opcode goes from acceptance
// straight to the result state; a push or a read passes its own working
// state first. Finish runs a prefix pass that reads and rewrites each of the
// MAX_GROUPS histogram entries through the registered read of the offset
// table, then a scatter pass with a key-store read, a cursor read and a write
// per item, the shared adder adding one to the cursor. The result sits in an
// output register, so the block returns to idle as soon as that register is
// free. The group count register may be written at any idle moment; it is
// saturated to the range 1 to MAX_GROUPS where it is used.
module counting_sort_grouper_core #(
    parameter int MAX_ITEMS  = csg_pkg::MAX_ITEMS_DEF,
    parameter int MAX_GROUPS = csg_pkg::MAX_GROUPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Command stream. tdata fields from bit 0: opcode[2:0], key[10:3],
    // index[21:11], zero padding[23:22].
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [csg_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // Result stream. tdata fields from bit 0: value[10:0], status[12:11],
    // zero padding[15:13].
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic      [csg_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // Group count register.
    input  wire logic                          i_cfg_we,
    input  wire logic [csg_pkg::GCFG_W-1:0]    i_cfg_wdata
);

    localparam int IAW = $clog2(MAX_ITEMS);       // item address
    localparam int CW  = $clog2(MAX_ITEMS + 1);   // counts and offsets
    localparam int GAW = $clog2(MAX_GROUPS);      // group address
    localparam int OAW = $clog2(MAX_GROUPS + 1);  // offset table address
    localparam int OPW = csg_pkg::OPCODE_W;
    localparam int KW  = csg_pkg::KEY_W;
    localparam int XW  = csg_pkg::INDEX_W;
    localparam int VW  = csg_pkg::VALUE_W;
    localparam int SW  = csg_pkg::STATUS_W;
    localparam int MW  = csg_pkg::M_TDATA_W;

    // Command fields.
    logic [OPW-1:0] w_opcode;
    logic [KW-1:0]  w_key;
    logic [XW-1:0]  w_index;

    assign w_opcode = i_s_axis_tdata[OPW-1:0];
    assign w_key    = i_s_axis_tdata[OPW +: KW];
    assign w_index  = i_s_axis_tdata[OPW + KW +: XW];

    // Control state.
    csg_pkg::t_state r_state, n_state;
    logic [csg_pkg::GCFG_W-1:0] r_group_count;
    logic [CW-1:0]              r_count;
    logic                       r_sorted;
    logic                       r_out_valid;

    // Working registers.
    logic [CW-1:0]  r_acc;
    logic [GAW-1:0] r_grp;
    logic [OAW-1:0] r_waddr;
    logic [IAW-1:0] r_item;
    logic [VW-1:0]  r_res_value;
    logic [SW-1:0]  r_res_status;
    logic [VW-1:0]  r_out_value;
    logic [SW-1:0]  r_out_status;

    // Datapath nets.
    logic           w_s_acc;
    logic           w_slot_free;
    logic [OAW-1:0] w_groups;
    logic           w_key_ok;
    logic           w_off_ok;
    logic           w_ord_ok;
    logic           w_last_item;
    logic [OAW-1:0] w_key_addr;

    logic [OAW-1:0] w_off_rd_addr;
    logic           w_off_wr_en;
    logic [CW-1:0]  w_off_rd;
    logic           w_ks_wr_en;
    logic [KW-1:0]  w_ks_rd;
    logic           w_cur_wr_en;
    logic [GAW-1:0] w_cur_wr_addr;
    logic [CW-1:0]  w_cur_wr_data;
    logic [CW-1:0]  w_cur_rd;
    logic           w_ord_wr_en;
    logic [IAW-1:0] w_ord_rd;

    // Shared adder operands and result.
    logic [CW-1:0]  w_add_a;
    logic [CW-1:0]  w_add_b;
    logic [CW-1:0]  w_sum;

    assign o_s_axis_tready = (r_state == csg_pkg::S_IDLE);
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot_free     = !r_out_valid || i_m_axis_tready;

    // Group count in use, saturated to 1..MAX_GROUPS.
    always_comb begin
        if (r_group_count == '0) begin
            w_groups = OAW'(1);
        end else if (32'(r_group_count) > 32'(MAX_GROUPS)) begin
            w_groups = OAW'(MAX_GROUPS);
        end else begin
            w_groups = OAW'(r_group_count);
        end
    end

    assign w_key_ok    = (32'(w_key) < 32'(w_groups)) && (r_count != CW'(MAX_ITEMS));
    assign w_off_ok    = (32'(w_index) <= 32'(w_groups));
    assign w_ord_ok    = (32'(w_index) < 32'(r_count));
    assign w_last_item = (CW'(r_item) == (r_count - CW'(1)));
    assign w_key_addr  = OAW'(w_key) + OAW'(1);
    assign w_sum       = w_add_a + w_add_b;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            csg_pkg::S_IDLE: begin
                if (w_s_acc) begin
                    case (w_opcode)
                        csg_pkg::OP_PUSH: begin
                            n_state = (!r_sorted && w_key_ok) ? csg_pkg::S_PUSH
                                                              : csg_pkg::S_RESP;
                        end
                        csg_pkg::OP_FINISH: begin
                            n_state = r_sorted ? csg_pkg::S_RESP : csg_pkg::S_PFX_RD;
                        end
                        csg_pkg::OP_RD_OFFSET: begin
                            n_state = (r_sorted && w_off_ok) ? csg_pkg::S_RD_OFF
                                                             : csg_pkg::S_RESP;
                        end
                        csg_pkg::OP_RD_ORDER: begin
                            n_state = (r_sorted && w_ord_ok) ? csg_pkg::S_RD_ORD
                                                             : csg_pkg::S_RESP;
                        end
                        default: begin
                            n_state = csg_pkg::S_RESP;
                        end
                    endcase
                end
            end
            csg_pkg::S_PUSH:   n_state = csg_pkg::S_RESP;
            csg_pkg::S_PFX_RD: n_state = csg_pkg::S_PFX_WR;
            csg_pkg::S_PFX_WR: begin
                if (r_grp == GAW'(MAX_GROUPS - 1)) begin
                    n_state = (r_count == '0) ? csg_pkg::S_RESP : csg_pkg::S_SC_KEY;
                end else begin
                    n_state = csg_pkg::S_PFX_RD;
                end
            end
            csg_pkg::S_SC_KEY: n_state = csg_pkg::S_SC_CUR;
            csg_pkg::S_SC_CUR: n_state = csg_pkg::S_SC_WR;
            csg_pkg::S_SC_WR: begin
                n_state = w_last_item ? csg_pkg::S_RESP : csg_pkg::S_SC_KEY;
            end
            csg_pkg::S_RD_OFF: n_state = csg_pkg::S_RESP;
            csg_pkg::S_RD_ORD: n_state = csg_pkg::S_RESP;
            csg_pkg::S_RESP: begin
                if (w_slot_free) begin
                    n_state = csg_pkg::S_IDLE;
                end
            end
            default: n_state = csg_pkg::S_IDLE;
        endcase
    end

    // Memory ports and adder operands for each state.
    always_comb begin
        w_off_rd_addr = (w_opcode == csg_pkg::OP_PUSH) ? w_key_addr : OAW'(w_index);
        w_off_wr_en   = 1'b0;
        w_ks_wr_en    = 1'b0;
        w_cur_wr_en   = 1'b0;
        w_cur_wr_addr = r_grp;
        w_cur_wr_data = r_acc;
        w_ord_wr_en   = 1'b0;
        w_add_a       = w_off_rd;
        w_add_b       = CW'(1);
        case (r_state)
            csg_pkg::S_IDLE: begin
                w_ks_wr_en = w_s_acc && (w_opcode == csg_pkg::OP_PUSH)
                             && !r_sorted && w_key_ok;
            end
            csg_pkg::S_PUSH: begin
                w_off_wr_en = 1'b1;
            end
            csg_pkg::S_PFX_RD: begin
                w_off_rd_addr = r_waddr;
            end
            csg_pkg::S_PFX_WR: begin
                // Running prefix: the old total is the cursor start of this
                // group, the new total becomes the offset of the next one.
                w_add_a     = r_acc;
                w_add_b     = w_off_rd;
                w_off_wr_en = 1'b1;
                w_cur_wr_en = 1'b1;
            end
            csg_pkg::S_SC_WR: begin
                w_add_a       = w_cur_rd;
                w_ord_wr_en   = 1'b1;
                w_cur_wr_en   = 1'b1;
                w_cur_wr_addr = GAW'(w_ks_rd);
                w_cur_wr_data = w_sum;
            end
            default: begin
            end
        endcase
    end

    csg_offset_table #(
        .DEPTH (MAX_GROUPS + 1),
        .WIDTH (CW)
    ) u_offset_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_s_acc && (w_opcode == csg_pkg::OP_CLEAR)),
        .i_rd_addr (w_off_rd_addr),
        .i_wr_en   (w_off_wr_en),
        .i_wr_addr (r_waddr),
        .i_wr_data (w_sum),
        .o_rd_data (w_off_rd)
    );

    csg_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (KW)
    ) u_key_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_ks_wr_en),
        .i_wr_addr (r_count[IAW-1:0]),
        .i_wr_data (w_key),
        .i_rd_addr (r_item),
        .o_rd_data (w_ks_rd)
    );

    csg_ram #(
        .DEPTH (MAX_GROUPS),
        .WIDTH (CW)
    ) u_cursor_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_cur_wr_en),
        .i_wr_addr (w_cur_wr_addr),
        .i_wr_data (w_cur_wr_data),
        .i_rd_addr (GAW'(w_ks_rd)),
        .o_rd_data (w_cur_rd)
    );

    csg_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (IAW)
    ) u_order_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_ord_wr_en),
        .i_wr_addr (IAW'(w_cur_rd)),
        .i_wr_data (r_item),
        .i_rd_addr (IAW'(w_index)),
        .o_rd_data (w_ord_rd)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= csg_pkg::S_IDLE;
            r_group_count <= csg_pkg::GCFG_RESET;
            r_count       <= '0;
            r_sorted      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_group_count <= i_cfg_wdata;
            end
            if (w_s_acc) begin
                case (w_opcode)
                    csg_pkg::OP_CLEAR: begin
                        r_count  <= '0;
                        r_sorted <= 1'b0;
                    end
                    csg_pkg::OP_PUSH: begin
                        if (!r_sorted && w_key_ok) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    csg_pkg::OP_FINISH: begin
                        r_sorted <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == csg_pkg::S_RESP && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_res_value <= '0;
            r_grp       <= '0;
            r_acc       <= '0;
            r_waddr     <= (w_opcode == csg_pkg::OP_FINISH) ? OAW'(1) : w_key_addr;
            case (w_opcode)
                csg_pkg::OP_PUSH: begin
                    r_res_status <= r_sorted ? csg_pkg::ST_PHASE
                                  : (w_key_ok ? csg_pkg::ST_OK : csg_pkg::ST_KEY);
                end
                csg_pkg::OP_FINISH: begin
                    r_res_status <= r_sorted ? csg_pkg::ST_PHASE : csg_pkg::ST_OK;
                end
                csg_pkg::OP_RD_OFFSET: begin
                    r_res_status <= !r_sorted ? csg_pkg::ST_PHASE
                                  : (w_off_ok ? csg_pkg::ST_OK : csg_pkg::ST_RANGE);
                end
                csg_pkg::OP_RD_ORDER: begin
                    r_res_status <= !r_sorted ? csg_pkg::ST_PHASE
                                  : (w_ord_ok ? csg_pkg::ST_OK : csg_pkg::ST_RANGE);
                end
                default: begin
                    r_res_status <= csg_pkg::ST_OK;
                end
            endcase
        end
        case (r_state)
            csg_pkg::S_PFX_WR: begin
                r_acc   <= w_sum;
                r_grp   <= r_grp + GAW'(1);
                r_waddr <= r_waddr + OAW'(1);
                r_item  <= '0;
            end
            csg_pkg::S_SC_WR: begin
                r_item <= r_item + IAW'(1);
            end
            csg_pkg::S_RD_OFF: begin
                r_res_value <= VW'(w_off_rd);
            end
            csg_pkg::S_RD_ORD: begin
                r_res_value <= VW'(w_ord_rd);
            end
            default: begin
            end
        endcase
        if (r_state == csg_pkg::S_RESP && w_slot_free) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = MW'({r_out_status, r_out_value});

    // The number of stored items never passes the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(MAX_ITEMS))
        else $error("item count beyond store depth");

    // A push accepted after finish is refused as a wrong-phase command.
    a_push_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && w_opcode == csg_pkg::OP_PUSH && r_sorted)
        |=> (r_state == csg_pkg::S_RESP && r_res_status == csg_pkg::ST_PHASE))
        else $error("push after finish not refused");

    // A flagged result always carries a zero value.
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csg_pkg::S_RESP && r_res_status != csg_pkg::ST_OK)
        |-> (r_res_value == '0))
        else $error("flagged result with non-zero value");

    // Scatter runs only in the sorted phase and places items inside the count.
    a_scatter_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csg_pkg::S_SC_WR) |-> (r_sorted && w_cur_rd < r_count))
        else $error("scatter position outside the stored items");

endmodule

`default_nettype wire

// ----- rtl/csg_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write and one registered read per cycle.
module csg_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    localparam int AW  = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/csg_offset_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Histogram and offset table. A valid bit per entry lets the clear command
// empty the whole table by clearing only those bits; an entry that is not valid reads as zero.
module csg_offset_table #(
    parameter int DEPTH = 257,
    parameter int WIDTH = 11,
    localparam int AW  = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire logic [AW-1:0]    i_rd_addr,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [DEPTH-1:0] r_valid;
    logic             r_rd_valid;
    logic [WIDTH-1:0] w_ram_rd;

    csg_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (w_ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[i_rd_addr];
    end

    assign o_rd_data = r_rd_valid ? w_ram_rd : '0;

endmodule

`default_nettype wire
